[src/alaw_playback_filter_oversampler_top_defines.svh]
// Assertion macros for the A-law playback filter checker.
// No dependencies; included by the checker file only.
`ifndef ALAW_PLAYBACK_FILTER_OVERSAMPLER_TOP_DEFINES_SVH
`define ALAW_PLAYBACK_FILTER_OVERSAMPLER_TOP_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define APF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("apf: next-cycle check failed");

// Consequent checked in the same cycle as the antecedent.
`define APF_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("apf: same-cycle check failed");

`endif

[src/apf_pkg.sv]
// Shared widths and the configuration bundle of the A-law playback filter.
// No dependencies; used by the front end, the back end and the top level.
`timescale 1ns / 1ps

package apf_pkg;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned LIN_W  = 16;
  localparam int unsigned GAIN_W = 20;
  localparam int unsigned DC_W   = 16;
  localparam int unsigned SMP_W  = 16;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic signed [DC_W-1:0]   dc_offset;
  } cfg_t;

endpackage

[src/apf_front.sv]
// Front end: accepts A-law bytes, expands them to 16-bit linear and queues them.
// Depends on apf_pkg.
`timescale 1ns / 1ps

module apf_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [apf_pkg::CODE_W-1:0]         s_axis_tdata,   // [7:0] alaw_code
  output logic                               lin_vld_o,
  output logic signed [apf_pkg::LIN_W-1:0]   lin_o,
  input  logic                               lin_pop_i
);

  function automatic logic [apf_pkg::LIN_W-1:0] alaw_expand(
    input logic [apf_pkg::CODE_W-1:0] code
  );
    logic [7:0]  a;
    logic [2:0]  seg;
    logic [14:0] t;
    logic [15:0] mag;
    a   = code ^ 8'h55;
    seg = a[6:4];
    t   = {7'd0, a[3:0], 4'd0};
    if (seg == 3'd0) begin
      t = t + 15'd8;
    end else begin
      t = (t + 15'h108) << (seg - 3'd1);
    end
    mag = {1'b0, t};
    return a[7] ? mag : (16'd0 - mag);
  endfunction

  logic [apf_pkg::LIN_W-1:0] mem_q [2];
  logic                      wr_ptr_q, rd_ptr_q;
  logic [1:0]                cnt_q;
  logic                      push, pop;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = lin_pop_i && (cnt_q != 2'd0);
  assign lin_vld_o     = (cnt_q != 2'd0);
  assign lin_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= alaw_expand(s_axis_tdata);
    end
  end

endmodule

[src/apf_back.sv]
// Back end: gain, high-pass biquad on one shared multiplier, offset, and the
// sample/midpoint pair register that drives the result stream. Depends on apf_pkg.
`timescale 1ns / 1ps

module apf_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  apf_pkg::cfg_t                    cfg_i,
  input  logic                             lin_vld_i,
  input  logic signed [apf_pkg::LIN_W-1:0] lin_i,
  output logic                             lin_pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [apf_pkg::SMP_W-1:0]        m_axis_tdata,   // [15:0] dac_sample
  output logic                             m_axis_tlast    // last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_ADD,
    ST_FIN,
    ST_EMIT
  } state_e;

  // Tap order: the gain product is still in the product register during the
  // first tap, so the new input sample comes last.
  localparam logic [2:0] TAP_X1 = 3'd0;
  localparam logic [2:0] TAP_X2 = 3'd1;
  localparam logic [2:0] TAP_Y1 = 3'd2;
  localparam logic [2:0] TAP_Y2 = 3'd3;
  localparam logic [2:0] TAP_X0 = 3'd4;

  localparam int unsigned MA_W  = 32;
  localparam int unsigned MB_W  = apf_pkg::GAIN_W;
  localparam int unsigned MP_W  = MA_W + MB_W;
  localparam int unsigned ACC_W = 48;

  localparam logic signed [MB_W-1:0] COEF_X0 = 20'sd14585;
  localparam logic signed [MB_W-1:0] COEF_X1 = -20'sd29170;
  localparam logic signed [MB_W-1:0] COEF_X2 = 20'sd14585;
  localparam logic signed [MB_W-1:0] COEF_Y1 = 20'sd29033;
  localparam logic signed [MB_W-1:0] COEF_Y2 = -20'sd12923;
  localparam logic signed [ACC_W-1:0] ROUND = 48'sd8192;

  localparam logic signed [MP_W-16:0] Q_MAX = 37'sd32767;
  localparam logic signed [MP_W-16:0] Q_MIN = -37'sd32768;
  localparam logic signed [32:0]      S_MAX = 33'sd32767;
  localparam logic signed [32:0]      S_MIN = -33'sd32768;

  state_e state_q;
  logic [2:0] tap_q;

  logic signed [15:0] x1_q, x2_q;
  logic signed [31:0] y1_q, y2_q;
  logic [15:0]        oh0_q, oh1_q;
  logic               out_vld_q, out_sel_q;

  logic signed [MP_W-1:0]  prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [15:0]      x0_q;
  logic [15:0]             s_q, samp_q, mid_q;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  mul_p;
  logic signed [MP_W-16:0] gp;
  logic signed [15:0]      x0_sat;
  logic                    inc;
  logic signed [31:0]      y_new;
  logic signed [32:0]      sum;
  logic [15:0]             sat16, s_new;
  logic [20:0]             num;
  logic [15:0]             mid_new;
  logic                    out_free, out_take, out_load;

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_IDLE) begin
      mul_a = {{(MA_W-apf_pkg::LIN_W){lin_i[apf_pkg::LIN_W-1]}}, lin_i};
      mul_b = cfg_i.gain;
    end else begin
      case (tap_q)
        TAP_X1: begin
          mul_a = {{16{x1_q[15]}}, x1_q};
          mul_b = COEF_X1;
        end
        TAP_X2: begin
          mul_a = {{16{x2_q[15]}}, x2_q};
          mul_b = COEF_X2;
        end
        TAP_Y1: begin
          mul_a = y1_q;
          mul_b = COEF_Y1;
        end
        TAP_Y2: begin
          mul_a = y2_q;
          mul_b = COEF_Y2;
        end
        TAP_X0: begin
          mul_a = {{16{x0_q[15]}}, x0_q};
          mul_b = COEF_X0;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // Floor the gain product by 2^15 and saturate to Q15.
  always_comb begin
    gp = prod_q[MP_W-1:15];
    if (gp > Q_MAX) begin
      x0_sat = 16'sh7FFF;
    end else if (gp < Q_MIN) begin
      x0_sat = -16'sh8000;
    end else begin
      x0_sat = gp[15:0];
    end
  end

  // Divide by 2^14 truncating toward zero, wrap to 32 bits, add offset, saturate, bias.
  always_comb begin
    inc   = acc_q[ACC_W-1] && (acc_q[13:0] != 14'd0);
    y_new = acc_q[45:14] + {31'd0, inc};
    sum   = {y_new[31], y_new} + {{17{cfg_i.dc_offset[15]}}, cfg_i.dc_offset};
    if (sum > S_MAX) begin
      sat16 = 16'h7FFF;
    end else if (sum < S_MIN) begin
      sat16 = 16'h8000;
    end else begin
      sat16 = sum[15:0];
    end
    s_new = {~sat16[15], sat16[14:0]};
  end

  // Midpoint (6*prev + 3*new - prev2) / 8; a negative sum clamps to zero, an overflow to 65535.
  always_comb begin
    num = ({5'd0, oh0_q} << 2) + ({5'd0, oh0_q} << 1)
        + ({5'd0, s_q} << 1) + {5'd0, s_q} - {5'd0, oh1_q};
    if (num[20]) begin
      mid_new = 16'd0;
    end else if (num[19]) begin
      mid_new = 16'hFFFF;
    end else begin
      mid_new = num[18:3];
    end
  end

  assign lin_pop_o     = (state_q == ST_IDLE) && lin_vld_i;
  assign out_take      = out_vld_q && m_axis_tready;
  assign out_free      = !out_vld_q || (out_sel_q && m_axis_tready);
  assign out_load      = (state_q == ST_EMIT) && out_free;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_sel_q;
  assign m_axis_tdata  = out_sel_q ? mid_q : samp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_q     <= TAP_X1;
      x1_q      <= '0;
      x2_q      <= '0;
      y1_q      <= '0;
      y2_q      <= '0;
      oh0_q     <= '0;
      oh1_q     <= '0;
      out_vld_q <= 1'b0;
      out_sel_q <= 1'b0;
    end else begin
      // A new pair loaded in this cycle takes over the result register.
      if (out_take && !out_load) begin
        if (out_sel_q) begin
          out_vld_q <= 1'b0;
        end else begin
          out_sel_q <= 1'b1;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (lin_vld_i) begin
            tap_q   <= TAP_X1;
            state_q <= ST_TAP;
          end
        end
        ST_TAP: begin
          if (tap_q == TAP_X0) begin
            state_q <= ST_ADD;
          end else begin
            tap_q <= tap_q + 3'd1;
          end
        end
        ST_ADD: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          x2_q    <= x1_q;
          x1_q    <= x0_q;
          y2_q    <= y1_q;
          y1_q    <= y_new;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            oh1_q     <= oh0_q;
            oh0_q     <= s_q;
            out_vld_q <= 1'b1;
            out_sel_q <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE || state_q == ST_TAP) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_TAP) begin
      if (tap_q == TAP_X1) begin
        x0_q  <= x0_sat;
        acc_q <= '0;
      end else begin
        acc_q <= acc_q + prod_q[ACC_W-1:0];
      end
    end
    if (state_q == ST_ADD) begin
      acc_q <= acc_q + prod_q[ACC_W-1:0] + ROUND;
    end
    if (state_q == ST_FIN) begin
      s_q <= s_new;
    end
    if (state_q == ST_EMIT && out_free) begin
      samp_q <= s_q;
      mid_q  <= mid_new;
    end
  end

endmodule

[src/alaw_playback_filter_oversampler_top.sv]
// A-law playback filter: for each accepted byte, its filtered sample and then the
// interpolated midpoint, in the cycle after the sink takes the sample. The front end queues
// bytes and the back end takes one at a time: gain and five biquad taps run one after another
// on a single 32x20 multiplier, then the last accumulate, offset and midpoint, a step each.
// Reset (rst_ni low, asynchronous) empties the queue and the result register,
// zeroes all filter and output history, and sets gain to 4096 and offset to 0.
`timescale 1ns / 1ps

module alaw_playback_filter_oversampler_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [apf_pkg::CODE_W-1:0]        s_axis_tdata,   // [7:0] alaw_code
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [apf_pkg::SMP_W-1:0]         m_axis_tdata,   // [15:0] dac_sample
  output logic                              m_axis_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_DC   = 1'b1;

  localparam logic signed [apf_pkg::GAIN_W-1:0] GAIN_MAX   = 20'sd262144;
  localparam logic signed [apf_pkg::GAIN_W-1:0] GAIN_MIN   = -20'sd262144;
  localparam logic signed [apf_pkg::GAIN_W-1:0] GAIN_RESET = 20'sd4096;

  apf_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic signed [apf_pkg::GAIN_W-1:0] gain_wr, gain_sat;

  logic                             lin_vld, lin_pop;
  logic signed [apf_pkg::LIN_W-1:0] lin;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    gain_wr = pwdata[apf_pkg::GAIN_W-1:0];
    if (gain_wr > GAIN_MAX) begin
      gain_sat = GAIN_MAX;
    end else if (gain_wr < GAIN_MIN) begin
      gain_sat = GAIN_MIN;
    end else begin
      gain_sat = gain_wr;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GAIN: prdata = {{(32-apf_pkg::GAIN_W){cfg_q.gain[apf_pkg::GAIN_W-1]}}, cfg_q.gain};
      REG_DC:   prdata = {{(32-apf_pkg::DC_W){cfg_q.dc_offset[apf_pkg::DC_W-1]}},
                          cfg_q.dc_offset};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain      <= GAIN_RESET;
      cfg_q.dc_offset <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_GAIN: cfg_q.gain      <= gain_sat;
        REG_DC:   cfg_q.dc_offset <= pwdata[apf_pkg::DC_W-1:0];
        default:  cfg_q           <= cfg_q;
      endcase
    end
  end

  apf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .lin_vld_o     (lin_vld),
    .lin_o         (lin),
    .lin_pop_i     (lin_pop)
  );

  apf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .lin_vld_i     (lin_vld),
    .lin_i         (lin),
    .lin_pop_o     (lin_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[src/apf_checker.sv]
// Port-level checks for the A-law playback filter, bound to the top level.
// Depends on alaw_playback_filter_oversampler_top_defines.svh for the macros.
`timescale 1ns / 1ps
`include "alaw_playback_filter_oversampler_top_defines.svh"

module apf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic        pready,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  logic        out_stall, smp_fire, mid_fire, cfg_dc_wr;
  logic [16:0] out_word;
  logic [15:0] dc_wdata, dc_rdata;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign smp_fire  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
  assign mid_fire  = m_axis_tvalid && m_axis_tready && m_axis_tlast;
  assign out_word  = {m_axis_tlast, m_axis_tdata};
  assign cfg_dc_wr = psel && penable && pwrite && pready && paddr[2];
  assign dc_wdata  = pwdata[15:0];
  assign dc_rdata  = prdata[15:0];

  // A stalled result holds its data and its position in the pair.
  `APF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_word))

  // The new sample is always followed by its midpoint.
  `APF_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, smp_fire, m_axis_tvalid && m_axis_tlast)

  // Two midpoints never go out back to back.
  `APF_ASSERT_NEXT(a_no_double_last, clk_i, rst_ni, mid_fire, !mid_fire)

  // A pair starts with the sample, never with the midpoint.
  `APF_ASSERT_NOW(a_pair_start, clk_i, rst_ni, $rose(m_axis_tvalid), !m_axis_tlast)

  // Offset written is read back unchanged.
  `APF_ASSERT_NEXT(a_dc_readback, clk_i, rst_ni, cfg_dc_wr, !paddr[2] || (dc_rdata == $past(dc_wdata)))

endmodule

bind alaw_playback_filter_oversampler_top apf_checker u_apf_checker (.*);

[tb/sv/alaw_playback_filter_oversampler_top_tb.sv]
// Testbench for the A-law playback filter: a stream driver and monitor, an APB writer
// and a bit-accurate predictor of the decode, gain, high-pass, offset and midpoint path.
// Depends on apf_pkg and alaw_playback_filter_oversampler_top.
`timescale 1ns / 1ps

module alaw_playback_filter_oversampler_top_tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS    = 125;

  localparam logic [2:0] ADDR_GAIN = 3'd0;
  localparam logic [2:0] ADDR_DC   = 3'd4;

  localparam longint GAIN_LIMIT = 262144;
  localparam longint HP_A0      = 14585;
  localparam longint HP_A1      = -29170;
  localparam longint HP_A2      = 14585;
  localparam longint HP_B1      = -29033;
  localparam longint HP_B2      = 12923;
  localparam longint HP_ROUND   = 8192;
  localparam longint HP_SCALE   = 16384;
  localparam longint DAC_BIAS   = 32768;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_e;

  typedef struct packed {
    logic [apf_pkg::SMP_W-1:0] sample;
    logic                      last;
  } dac_result_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [apf_pkg::CODE_W-1:0] s_axis_tdata  = '0;   // [7:0] alaw_code
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [apf_pkg::SMP_W-1:0]  m_axis_tdata;         // [15:0] dac_sample
  logic                       m_axis_tlast;
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [2:0]                 paddr         = '0;
  logic [31:0]                pwdata        = '0;
  logic [31:0]                prdata;
  logic                       pready;

  alaw_playback_filter_oversampler_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: registers and filter/output history
  longint gain_q15 = 4096;
  longint dc_q15   = 0;
  longint hp_x[2]  = '{0, 0};
  longint hp_y[2]  = '{0, 0};
  longint dac_hist[2] = '{0, 0};

  logic [apf_pkg::CODE_W-1:0] alaw_tx_q[$];
  dac_result_t                dac_expect_q[$];

  int unsigned n_errors     = 0;
  int unsigned n_codes      = 0;
  int unsigned n_results    = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned idle_cycles  = 0;

  // Sender and receiver pacing
  bit          tx_bursty  = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  bit          s_taken    = 1'b0;
  rx_mode_e    rx_mode    = RX_ALWAYS;
  int unsigned rx_stall_n = 0;
  int unsigned rx_cnt     = 0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint alaw_to_linear(input logic [apf_pkg::CODE_W-1:0] code);
    logic [7:0] a;
    longint     mag;
    int         seg;
    a   = code ^ 8'h55;
    mag = longint'(a[3:0]) << 4;
    seg = int'(a[6:4]);
    if (seg == 0) begin
      mag += 8;
    end else if (seg == 1) begin
      mag += 'h108;
    end else begin
      mag = (mag + 'h108) << (seg - 1);
    end
    return a[7] ? mag : -mag;
  endfunction

  // Push the new sample and its midpoint for one accepted code.
  function void predict_dac_pair(input logic [apf_pkg::CODE_W-1:0] code);
    longint      x0;
    longint      acc;
    longint      y0;
    longint      smp;
    longint      mid;
    dac_result_t res;
    x0  = clamp((alaw_to_linear(code) * gain_q15) >>> 15, -32768, 32767);
    acc = HP_A0 * x0 + HP_A1 * hp_x[0] + HP_A2 * hp_x[1]
        - HP_B1 * hp_y[0] - HP_B2 * hp_y[1];
    y0  = (acc + HP_ROUND) / HP_SCALE;
    hp_x[1] = hp_x[0];
    hp_x[0] = x0;
    hp_y[1] = hp_y[0];
    hp_y[0] = longint'(int'(y0));
    smp = clamp(hp_y[0] + dc_q15, -32768, 32767) + DAC_BIAS;
    mid = clamp((6 * dac_hist[0] + 3 * smp - dac_hist[1]) / 8, 0, 65535);
    dac_hist[1] = dac_hist[0];
    dac_hist[0] = smp;
    res.sample = smp[apf_pkg::SMP_W-1:0];
    res.last   = 1'b0;
    dac_expect_q.push_back(res);
    res.sample = mid[apf_pkg::SMP_W-1:0];
    res.last   = 1'b1;
    dac_expect_q.push_back(res);
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_GAIN) begin
      gain_q15 = clamp(longint'($signed(value[apf_pkg::GAIN_W-1:0])),
                       -GAIN_LIMIT, GAIN_LIMIT);
    end else if (addr == ADDR_DC) begin
      dc_q15 = longint'($signed(value[apf_pkg::DC_W-1:0]));
    end
    n_cfg_writes++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_drained();
    while (alaw_tx_q.size() != 0 || dac_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random_codes(input int unsigned n);
    int unsigned left;
    int unsigned run;
    logic [7:0]  c0;
    logic [7:0]  c1;
    left = n;
    while (left > 0) begin
      c0  = 8'($urandom);
      c1  = 8'($urandom);
      run = $urandom_range(4, 12);
      if (run > left) run = left;
      case ($urandom_range(0, 9))
        6, 7: begin
          // hold a constant code to watch the high-pass decay
          repeat (run) alaw_tx_q.push_back(c0);
        end
        8: begin
          for (int i = 0; i < run; i++) alaw_tx_q.push_back(i[0] ? c1 : c0);
        end
        default: begin
          run = 1;
          alaw_tx_q.push_back(c0);
        end
      endcase
      left -= run;
    end
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 32'(GAIN_LIMIT);
      1:       return -32'(GAIN_LIMIT);
      2:       return 32'd0;
      3:       return 32'd32768;
      4:       return $urandom;    // any 20-bit pattern, out of range too
      default: return 32'($signed($urandom_range(0, 2 * GAIN_LIMIT)) - GAIN_LIMIT);
    endcase
  endfunction

  function automatic logic [31:0] pick_dc();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_7FFF;
      1:       return 32'hFFFF_8000;
      2:       return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // Stream driver: bursts with random gaps when bursty, else steady; hold the item until it is taken.
  always @(negedge clk_i) begin
    if (!(s_axis_tvalid && !s_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (alaw_tx_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= alaw_tx_q[0];
        if (burst_left > 0) begin
          burst_left--;
        end else if (tx_bursty) begin
          burst_left = $urandom_range(0, 15);
          gap_left   = $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink stall pattern
  always @(negedge clk_i) begin
    rx_cnt++;
    case (rx_mode)
      RX_ALWAYS:   m_axis_tready <= 1'b1;
      RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 2) != 0);
      RX_PERIODIC: m_axis_tready <= ((rx_cnt % 8) >= rx_stall_n);
      default:     m_axis_tready <= 1'b1;
    endcase
  end

  // Monitor: predict on each input transaction, check each output transaction.
  always @(posedge clk_i) begin
    dac_result_t exp_res;
    s_taken = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        s_taken = 1'b1;
        void'(alaw_tx_q.pop_front());
        predict_dac_pair(s_axis_tdata);
        n_codes++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (dac_expect_q.size() == 0) begin
          $error("unexpected result: dac_sample %0d last %0b", m_axis_tdata, m_axis_tlast);
          n_errors++;
        end else begin
          exp_res = dac_expect_q.pop_front();
          if (m_axis_tdata !== exp_res.sample) begin
            $error("dac_sample mismatch: expected %0d, actual %0d",
                   exp_res.sample, m_axis_tdata);
            n_errors++;
          end
          if (m_axis_tlast !== exp_res.last) begin
            $error("last mismatch: expected %0b, actual %0b", exp_res.last, m_axis_tlast);
            n_errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults, history starts from zero: extremes and each sign boundary
    alaw_tx_q = '{8'hD5, 8'h55, 8'hAA, 8'h2A, 8'hAA, 8'hAA, 8'h2A, 8'h2A,
                  8'h00, 8'hFF, 8'h80, 8'h7F};
    wait_drained();

    // Gain above +8.0 saturates, largest offset
    write_reg(ADDR_GAIN, 32'h0007_FFFF);
    write_reg(ADDR_DC, 32'h0000_7FFF);
    alaw_tx_q = '{8'hAA, 8'hAA, 8'h2A, 8'h2A, 8'hD5, 8'h55};
    wait_drained();

    // Gain below -8.0 saturates, most negative offset
    write_reg(ADDR_GAIN, 32'hFFF8_0000);
    write_reg(ADDR_DC, 32'hFFFF_8000);
    alaw_tx_q = '{8'h2A, 8'hAA, 8'h2A, 8'hD5, 8'hFF, 8'h00};
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(ADDR_GAIN, pick_gain());
      write_reg(ADDR_DC, pick_dc());
      tx_bursty  = (p % 4) != 0;
      rx_mode    = rx_mode_e'(p % 3);
      rx_stall_n = $urandom_range(1, 6);
      queue_random_codes(PHASE_ITEMS);
      wait_drained();
    end

    $display("covered %0d A-law codes, %0d DAC results checked, %0d register writes",
             n_codes, n_results, n_cfg_writes);
    $display("gain and offset at both limits, bursty and steady sender, three sink patterns");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/apf_pkg.sv
src/apf_front.sv
src/apf_back.sv
src/alaw_playback_filter_oversampler_top.sv
src/apf_checker.sv
tb/sv/alaw_playback_filter_oversampler_top_tb.sv
